>>> rtl/sha1_message_digest_macros.svh
// Assertion shorthands shared by the digest RTL.
// Both forms sample on clock and are muted while reset is high.
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication.
`define SMD_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SMD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sha1md_pkg.sv
package sha1md_pkg;

   localparam int WordW       = 32;
   localparam int BlockWords  = 16;
   localparam int DigestWords = 5;
   localparam int NumRounds   = 80;

   typedef logic [WordW-1:0] word_type;
   typedef logic [DigestWords-1:0][WordW-1:0] chain_type;
   typedef logic [6:0] round_idx_type;
   typedef logic [3:0] fill_type;
   typedef logic [2:0] digest_idx_type;

   localparam round_idx_type LastRound = round_idx_type'(NumRounds - 1);

   // entry 0 is h0
   localparam chain_type InitChain = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };

   localparam word_type MarkWord = 32'h80000000;

   typedef struct packed {
      logic start;   // load working vars from chain, begin 80 rounds
      logic init;    // chain back to initial values
   } round_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;    // one cycle: chain picks up the working vars
   } round_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      PH_NONE,
      PH_FIRST,
      PH_MARK,
      PH_ZERO,
      PH_LENLO,
      PH_DONE
   } pad_type;

   function automatic word_type round_k(round_idx_type t);
      word_type k;
      if (t < round_idx_type'(20))      k = 32'h5a827999;
      else if (t < round_idx_type'(40)) k = 32'h6ed9eba1;
      else if (t < round_idx_type'(60)) k = 32'h8f1bbcdc;
      else                              k = 32'hca62c1d6;
      return k;
   endfunction

   function automatic word_type round_f(round_idx_type t, word_type b, word_type c,
                                        word_type d);
      word_type f;
      if (t < round_idx_type'(20))      f = d ^ (b & (c ^ d));
      else if (t < round_idx_type'(40)) f = b ^ c ^ d;
      else if (t < round_idx_type'(60)) f = (b & c) | (b & d) | (c & d);
      else                              f = b ^ c ^ d;
      return f;
   endfunction

   // Final partial word: keep the leading valid bytes, put 0x80 right after them; a full word is returned unchanged.
   function automatic word_type pad_word(word_type msg, logic [2:0] nv);
      word_type w;
      case (nv)
         3'd0:    w = MarkWord;
         3'd1:    w = (msg & 32'hff000000) | 32'h00800000;
         3'd2:    w = (msg & 32'hffff0000) | 32'h00008000;
         3'd3:    w = (msg & 32'hffffff00) | 32'h00000080;
         default: w = msg;
      endcase
      return w;
   endfunction

endpackage

>>> rtl/sha1_message_digest.sv
// Channel  Dir  Bits  Contents (low bit up)
// req      in   40    tdata: msg_word[31:0], bytes_valid[34:32], zero[39:35]; tlast: is_last
// rsp      out  40    tdata: digest_word[31:0], word_number[34:32], zero[39:35];
//                     tlast: final_word
//
// A message word is taken on each accepted handshake; the 16th word of a block
// starts an 80-round compression (one round per cycle), after which the working
// variables fold into the chaining value and the next word can be taken.
// A last item adds padding words, one per cycle between compressions, with one
// or two compressions, then five digest items. Synchronous reset returns to
// the initial chaining value with an empty block. req_tready is low while
// compressing, padding and emitting; a stalled rsp holds the current digest item.
`include "sha1_message_digest_macros.svh"

module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // msg_word[31:0], bytes_valid[34:32], zero fill
   input  logic        req_tlast,   // is_last

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_number[34:32], zero fill
   output logic        rsp_tlast    // final_word
);

   state_type      state_ff, state_in;
   pad_type        phase_ff, phase_in;
   fill_type       fill_ff, fill_in;
   logic [63:0]    bits_ff, bits_in;
   digest_idx_type emit_ff, emit_in;
   word_type       last_word_ff, last_word_in;   // final item, held for padding
   logic [2:0]     last_nv_ff, last_nv_in;

   word_type       msg_word;
   logic [2:0]     bytes_valid;
   logic [2:0]     nv_clamped;
   logic           req_accept;

   logic           push;
   word_type       push_word;
   logic           shift_en;
   word_type       shift_d;
   word_type       feedback;
   word_type       cell_q [BlockWords];
   word_type       digest_word;

   round_ctl_type  ctl;
   round_sts_type  sts;
   chain_type      chain;

   assign msg_word    = req_tdata[31:0];
   assign bytes_valid = req_tdata[34:32];
   assign nv_clamped  = (bytes_valid > 3'd4) ? 3'd4 : bytes_valid;
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;

   // schedule line: cell 0 holds w[t], cell 15 is loaded last
   for (genvar i = 0; i < BlockWords; i++) begin : g_sched
      word_type d;
      if (i == BlockWords - 1) begin : g_tail
         assign d = shift_d;
      end else begin : g_link
         assign d = cell_q[i+1];
      end
      sha1md_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d        (d),
         .q        (cell_q[i])
      );
   end

   // w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
   always_comb begin
      word_type x;
      x        = cell_q[13] ^ cell_q[8] ^ cell_q[2] ^ cell_q[0];
      feedback = {x[30:0], x[31]};
   end

   sha1md_round u_round (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .wt    (cell_q[0]),
      .sts   (sts),
      .chain (chain)
   );

   always_comb begin
      case (emit_ff)
         3'd0:    digest_word = chain[0];
         3'd1:    digest_word = chain[1];
         3'd2:    digest_word = chain[2];
         3'd3:    digest_word = chain[3];
         3'd4:    digest_word = chain[4];
         default: digest_word = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      emit_in      = emit_ff;
      last_word_in = last_word_ff;
      last_nv_in   = last_nv_ff;
      push         = 1'b0;
      push_word    = '0;
      ctl          = '0;
      rsp_tvalid   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_tlast) begin
                  push      = 1'b1;
                  push_word = msg_word;
                  bits_in   = bits_ff + 64'd32;
               end else begin
                  bits_in      = bits_ff + 64'({nv_clamped, 3'b000});
                  last_word_in = msg_word;
                  last_nv_in   = nv_clamped;
                  phase_in     = PH_FIRST;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push = 1'b1;
            case (phase_ff)
               PH_FIRST: begin
                  push_word = pad_word(last_word_ff, last_nv_ff);
                  phase_in  = (last_nv_ff == 3'd4) ? PH_MARK : PH_ZERO;
               end
               PH_MARK: begin
                  push_word = MarkWord;
                  phase_in  = PH_ZERO;
               end
               PH_ZERO: begin
                  if (fill_ff == fill_type'(BlockWords - 2)) begin
                     push_word = bits_ff[63:32];
                     phase_in  = PH_LENLO;
                  end
               end
               PH_LENLO: begin
                  push_word = bits_ff[31:0];
                  phase_in  = PH_DONE;
               end
               default: begin
                  push = 1'b0;
               end
            endcase
         end
         ST_ROUND: begin
            if (sts.done) begin
               if (phase_ff == PH_NONE)      state_in = ST_IDLE;
               else if (phase_ff == PH_DONE) state_in = ST_EMIT;
               else                          state_in = ST_PAD;
            end
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (emit_ff == digest_idx_type'(DigestWords - 1)) begin
                  emit_in  = '0;
                  ctl.init = 1'b1;
                  bits_in  = '0;
                  phase_in = PH_NONE;
                  state_in = ST_IDLE;
               end else begin
                  emit_in = emit_ff + digest_idx_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // count each pushed word; block full: compress it
      if (push) begin
         fill_in = fill_ff + fill_type'(1);
         if (fill_ff == fill_type'(BlockWords - 1)) begin
            ctl.start = 1'b1;
            state_in  = ST_ROUND;
         end
      end
   end

   assign shift_en = push || sts.busy;
   assign shift_d  = sts.busy ? feedback : push_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_NONE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         emit_ff  <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      last_word_ff <= last_word_in;
      last_nv_ff   <= last_nv_in;
   end

   assign rsp_tdata = {5'b00000, emit_ff, digest_word};
   assign rsp_tlast = (emit_ff == digest_idx_type'(DigestWords - 1));

   `SMD_ASSERT_IMPL(a_no_take_while_emit, rsp_tvalid, !req_tready, "input taken during digest")
   `SMD_ASSERT_IMPL(a_start_on_full, ctl.start, fill_ff == fill_type'(BlockWords - 1), "compress on partial block")
   `SMD_ASSERT_NEXT(a_restart, rsp_tvalid && rsp_tready && rsp_tlast, (state_ff == ST_IDLE) && (bits_ff == '0) && (fill_ff == '0), "no clean restart after digest")

endmodule

>>> rtl/sha1md_cell.sv
// One 32-bit slot of the message schedule line.
module sha1md_cell
   import sha1md_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  word_type d,
   output word_type q
);

   word_type word_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         word_ff <= d;
      end
   end

   assign q = word_ff;

endmodule

>>> rtl/sha1md_round.sv
`include "sha1_message_digest_macros.svh"

// Working variables a..e, round counter and chaining value.
module sha1md_round
   import sha1md_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  round_ctl_type ctl,
   input  word_type      wt,
   output round_sts_type sts,
   output chain_type     chain
);

   chain_type     chain_ff, chain_in;
   chain_type     vars_ff, vars_in;     // [0] = a ... [4] = e
   round_idx_type t_ff, t_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   word_type      tmp;

   always_comb begin
      tmp = {vars_ff[0][26:0], vars_ff[0][31:27]}
          + round_f(t_ff, vars_ff[1], vars_ff[2], vars_ff[3])
          + vars_ff[4] + round_k(t_ff) + wt;

      vars_in  = vars_ff;
      t_in     = t_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      chain_in = chain_ff;

      if (ctl.start) begin
         vars_in = chain_ff;
         t_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         vars_in[0] = tmp;
         vars_in[1] = vars_ff[0];
         vars_in[2] = {vars_ff[1][1:0], vars_ff[1][31:2]};
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3];
         t_in       = t_ff + round_idx_type'(1);
         if (t_ff == LastRound) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      if (done_ff) begin
         for (int i = 0; i < DigestWords; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end

      if (ctl.init) begin
         chain_in = InitChain;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= InitChain;
         vars_ff  <= '0;
         t_ff     <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         chain_ff <= chain_in;
         vars_ff  <= vars_in;
         t_ff     <= t_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign chain    = chain_ff;

   `SMD_ASSERT_NEXT(a_start_runs, ctl.start, busy_ff && (t_ff == '0), "start did not begin rounds")
   `SMD_ASSERT_NEXT(a_last_round_done, busy_ff && (t_ff == LastRound), done_ff && !busy_ff, "no done after round 79")
   `SMD_ASSERT_IMPL(a_no_restart, busy_ff || done_ff, !ctl.start, "start during compression")

endmodule
